### hw/rtl/uvl_pkg.sv
// Shared types, codes and constants of the unique value list table.
`timescale 1ns / 1ps

package uvl_pkg;

    // Default number of table entries.
    localparam int DEPTH_DEF = 16;

    // Operation codes of a request beat.
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_SEARCH = 2'd3
    } func_t;

    // Status codes of a response beat.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    // Request beat payload.
    typedef struct packed {
        func_t              func;
        logic signed [31:0] value;
    } req_t;

    // Response beat payload.
    typedef struct packed {
        status_t    status;
        logic [3:0] position;
        logic [4:0] count;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic shift_init;
        logic shift;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic do_shift;
        logic shift_done;
        logic rsp_busy;
    } dp_status_t;

endpackage

### hw/rtl/uvl_datapath.sv
// Datapath of the unique value list table: entry memory, scan and shift pointers, response register.
`timescale 1ns / 1ps

module uvl_datapath
    import uvl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    input  ctrl_cmd_t  cmd,
    input  logic       rsp_stall,
    output dp_status_t dp_stat,
    output rsp_t       rsp,
    output logic       rsp_valid
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = IW + 1;

    // Entry memory with a registered read port.
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    // Captured request and result payload.
    func_t              func_reg;
    logic signed [31:0] value_reg;
    logic [IW-1:0]      pidx_reg;
    logic [IW-1:0]      hidx_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    // Control state.
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic          pend_reg;
    logic          pend_next;
    logic          hit_reg;
    logic          hit_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;

    logic          full;
    logic          skip;
    logic          match;
    logic          more;
    logic          issue;
    logic          shift_wr;
    logic          ins_wr;
    logic [IW-1:0] wr_idx;

    // Decode of the scan and shift steps.
    always_comb
    begin
        full     = cnt_reg >= CW'(DEPTH);
        skip     = (func_reg == FUNC_CLEAR) || ((func_reg == FUNC_INSERT) && full);
        match    = pend_reg && (rd_data_reg == value_reg);
        more     = idx_reg < cnt_reg;
        issue    = (cmd.scan && !skip && !hit_reg && !match && more) || (cmd.shift && more);
        shift_wr = cmd.shift && pend_reg;
        ins_wr   = cmd.finish && (func_reg == FUNC_INSERT) && !full && !hit_reg;
        wr_idx   = pidx_reg - IW'(1);
    end

    // Memory: one read and one write a cycle.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[IW-1:0]];
        end
        if (shift_wr)
        begin
            mem[wr_idx] <= rd_data_reg;
        end
        else if (ins_wr)
        begin
            mem[cnt_reg[IW-1:0]] <= value_reg;
        end
    end

    // Result of the finished operation and the new count.
    always_comb
    begin
        rsp_next.status   = ST_OK;
        rsp_next.position = 4'd0;
        cnt_next          = cnt_reg;
        case (func_reg)
            FUNC_CLEAR:
            begin
                cnt_next = '0;
            end
            FUNC_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else if (hit_reg)
                begin
                    rsp_next.status = ST_DUP;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            FUNC_DELETE:
            begin
                if (hit_reg)
                begin
                    rsp_next.position = 4'(hidx_reg);
                    cnt_next          = cnt_reg - CW'(1);
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
            default:
            begin
                if (hit_reg)
                begin
                    rsp_next.position = 4'(hidx_reg);
                end
                else
                begin
                    rsp_next.status = ST_MISS;
                end
            end
        endcase
        rsp_next.count = 5'(cnt_next);
    end

    // Next values of the control state.
    always_comb
    begin
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
        end
        if (cmd.scan || cmd.shift)
        begin
            pend_next = issue;
            idx_next  = idx_reg + CW'(issue);
        end
        if (cmd.scan && match)
        begin
            hit_next = 1'b1;
        end
        if (cmd.shift_init)
        begin
            idx_next  = CW'(hidx_reg) + CW'(1);
            pend_next = 1'b0;
        end
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cmd.finish ? cnt_next : cnt_reg;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= req.func;
            value_reg <= req.value;
        end
        if (issue)
        begin
            pidx_reg <= idx_reg[IW-1:0];
        end
        if (cmd.scan && match)
        begin
            hidx_reg <= pidx_reg;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Status toward the controller and the response port.
    always_comb
    begin
        dp_stat.scan_done  = skip || hit_reg || (!pend_reg && !more);
        dp_stat.do_shift   = (func_reg == FUNC_DELETE) && hit_reg;
        dp_stat.shift_done = !pend_reg && !more;
        dp_stat.rsp_busy   = rsp_valid_reg && rsp_stall;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // The count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds table size");

    // A shift step only moves an entry that lies below the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        shift_wr |-> (CW'(pidx_reg) < cnt_reg) && (pidx_reg != '0))
        else $error("shift moves an entry outside the table");

    // A finished operation always presents a response beat next.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.finish |=> rsp_valid_reg)
        else $error("finished operation produced no response beat");

endmodule

### hw/rtl/uvl_ctrl.sv
// Controller of the unique value list table: sequences load, scan, shift and response.
`timescale 1ns / 1ps

module uvl_ctrl
    import uvl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  dp_status_t dp_stat,
    output ctrl_cmd_t  cmd,
    output logic       req_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (dp_stat.scan_done)
                begin
                    if (dp_stat.do_shift)
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (dp_stat.shift_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!dp_stat.rsp_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    // State and registered stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign req_stall = stall_reg;

    // Stall is raised exactly while an operation is in progress.
    assert property (@(posedge clk) disable iff (!rst_n) stall_reg == (state_reg != S_IDLE))
        else $error("request stall out of step with controller state");

    // An accepted request blocks the next one until its response is issued.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> stall_reg)
        else $error("request channel open while an operation runs");

    // At most one major command is active in a cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.shift, cmd.finish}))
        else $error("conflicting datapath commands");

endmodule

### hw/rtl/unique_value_list_table.sv
// Top level of the unique value list table.
`timescale 1ns / 1ps
//
// Holds a set of distinct signed 32-bit values in insertion order. Each request
// beat carries an operation (clear, insert, delete, search) and a value; each
// one yields exactly one response beat with a status, a position and the count.
// Both channels use valid and stall; a beat moves when valid is high and stall
// is low. The request stall is high from the cycle after a beat is accepted
// until its response has been loaded into the output register.
// Entries are read one a cycle through a single comparator on a one-port-read
// memory; a scan that hits stops early. A delete that hits then moves each
// later entry down through the same port. A clear, an insert into a full
// table or any operation on an empty table reads no entry. The response beat
// is offered in the cycle in which the next request can first be accepted.
// The output register lets a new request be accepted while a response waits;
// if the receiver stalls, the next operation holds before its response until
// the register is free. Reset empties the table at once; entry contents are
// not cleared.

module unique_value_list_table
    import uvl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_stat;

    // Operation sequencer.
    uvl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .dp_stat   (dp_stat),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    // Table storage and compare logic.
    uvl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .dp_stat   (dp_stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

endmodule
